>>> rtl/vtp_pkg.sv
// Package for the vertex transform / project core: fixed-point format,
// pipeline widths, opcodes and register indexes. No dependencies.
package vtp_pkg;

    // Fixed-point format of coefficients, vertices and results
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;

    // Row sum: three floored products plus the offset column
    localparam int PROD_W = 2 * DATA_W;
    localparam int SUM_W  = PROD_W - FRAC_BITS + 2;

    // Quotient magnitude is capped at 2^CAP_EXP
    localparam int CAP_EXP = 40;
    localparam int QUO_W   = CAP_EXP + 1;
    localparam int REM_W   = SUM_W + 1;
    localparam int PRE_SH  = QUO_W - FRAC_BITS;

    // Normalized coordinate after cap and the half offset
    localparam int NDC_W = QUO_W + 2;

    // Screen size registers
    localparam int DIM_W    = 13;
    localparam int CFG_IX_W = 2;
    localparam int SCR_W    = NDC_W + 1 + DIM_W + 1;

    // Stream payload widths
    localparam int IDX_W    = 4;
    localparam int IN_BITS  = IDX_W + 4 * DATA_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = 3 * DATA_W;

    typedef enum logic {
        OP_LOAD      = 1'b0,
        OP_TRANSFORM = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1
    } t_cfg_index;

endpackage

>>> rtl/vertex_transform_project_core.sv
// Vertex transform, perspective divide and viewport map, fully pipelined.
// Depends on vtp_pkg.
//
// Channel  | Direction | Payload
// s_axis   | in        | tuser: opcode; tdata: coeff_index, coeff_value, vertex_x/y/z
// m_axis   | out       | tuser: w_zero; tdata: screen_x, screen_y, depth
// cfg      | in        | index: register (0 width, 1 height); data: 13-bit value
//
// One transaction per cycle unless the output stalls. A transform passes 48 register
// stages: input, multiply, row sum, divide setup, 41 one-bit divide steps, cap and
// offset, viewport multiply, saturate. The 41-step restoring divider makes up most
// of the pipeline.
// Loads update the matrix at acceptance and use no output slot.
// Reset (synchronous, active low) restores the identity matrix and 640x480.
// A stalled output freezes every stage; nothing is dropped or repeated.
module vertex_transform_project_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // stream in
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [3:0] coeff_index, [35:4] coeff_value, [67:36] vertex_x,
    // [99:68] vertex_y, [131:100] vertex_z, rest zero
    input  logic [vtp_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // [0] opcode
    input  logic                            i_s_axis_tuser,
    // stream out
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [31:0] screen_x, [63:32] screen_y, [95:64] depth
    output logic [vtp_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // [0] w_zero
    output logic                            o_m_axis_tuser,
    // configuration
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [vtp_pkg::CFG_IX_W-1:0]    i_cfg_index,
    input  logic [vtp_pkg::DIM_W-1:0]       i_cfg_data
);
    import vtp_pkg::*;

    localparam logic signed [NDC_W-1:0] HALF_C = NDC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [NDC_W:0]   ONE_C  = (NDC_W+1)'(1) <<< FRAC_BITS;
    localparam logic [QUO_W-1:0]        CAP_C  = QUO_W'(1) << CAP_EXP;

    function automatic logic [DATA_W-1:0] sat32(input logic signed [SCR_W-1:0] v);
        logic signed [SCR_W-1:0] hi;
        logic signed [SCR_W-1:0] lo;
        hi = SCR_W'({1'b0, {(DATA_W-1){1'b1}}});
        lo = -hi - SCR_W'(1);
        if (v > hi) begin
            return hi[DATA_W-1:0];
        end else if (v < lo) begin
            return lo[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

    // global advance: every stage moves when the output register is free or taken
    logic w_en;
    logic w_in_acc;
    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign w_in_acc        = i_s_axis_tvalid && w_en;
    assign o_cfg_ready     = 1'b1;

    // configuration registers
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(640);
            r_height <= DIM_W'(480);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // matrix coefficients, written at acceptance of a load
    logic signed [DATA_W-1:0] r_mat [16];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_mat[i] <= ((i / 4) == (i % 4)) ? DATA_W'(1) <<< FRAC_BITS : '0;
            end
        end else if (w_in_acc && (t_opcode'(i_s_axis_tuser) == OP_LOAD)) begin
            r_mat[i_s_axis_tdata[IDX_W-1:0]] <= i_s_axis_tdata[IDX_W +: DATA_W];
        end
    end

    // stage 0: input register
    logic                     r_s0_v;
    logic signed [DATA_W-1:0] r_s0_c [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (w_en) begin
            r_s0_v <= w_in_acc && (t_opcode'(i_s_axis_tuser) == OP_TRANSFORM);
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_s0_c[c] <= i_s_axis_tdata[IDX_W + DATA_W*(c+1) +: DATA_W];
            end
        end
    end

    // stage 1: twelve products and the offset column
    logic                     r_s1_v;
    logic signed [PROD_W-1:0] r_s1_p   [4][3];
    logic signed [DATA_W-1:0] r_s1_off [4];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= r_s0_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_s1_p[r][c] <= r_mat[r*4+c] * r_s0_c[c];
                end
                r_s1_off[r] <= r_mat[r*4+3];
            end
        end
    end

    // stage 2: floored products summed per row
    logic                    r_s2_v;
    logic signed [SUM_W-1:0] r_s2_sum [4];
    logic signed [SUM_W-1:0] n_s2_sum [4];
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            n_s2_sum[r] = SUM_W'(r_s1_off[r]);
            for (int c = 0; c < 3; c++) begin
                n_s2_sum[r] = n_s2_sum[r] + SUM_W'(r_s1_p[r][c] >>> FRAC_BITS);
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_en) begin
            r_s2_v <= r_s1_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_sum <= n_s2_sum;
        end
    end

    // divider: entry 0 is setup (signs, magnitudes, overflow), then one bit per stage
    logic               r_dv_v    [QUO_W+1];
    logic               r_dv_zero [QUO_W+1];
    logic [SUM_W-1:0]   r_dv_nw   [QUO_W+1];
    logic [REM_W-1:0]   r_dv_rem  [3][QUO_W+1];
    logic [QUO_W-1:0]   r_dv_quo  [3][QUO_W+1];
    logic               r_dv_neg  [3][QUO_W+1];
    logic               r_dv_ovf  [3][QUO_W+1];

    logic [SUM_W-1:0] n_na [3];
    logic [SUM_W-1:0] n_nw;
    always_comb begin
        n_nw = r_s2_sum[3][SUM_W-1] ? SUM_W'(-r_s2_sum[3]) : SUM_W'(r_s2_sum[3]);
        for (int c = 0; c < 3; c++) begin
            n_na[c] = r_s2_sum[c][SUM_W-1] ? SUM_W'(-r_s2_sum[c]) : SUM_W'(r_s2_sum[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (w_en) begin
            r_dv_v[0] <= r_s2_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_zero[0] <= (r_s2_sum[3] == '0);
            r_dv_nw[0]   <= n_nw;
            for (int c = 0; c < 3; c++) begin
                r_dv_neg[c][0] <= r_s2_sum[c][SUM_W-1] ^ r_s2_sum[3][SUM_W-1];
                r_dv_ovf[c][0] <= (SUM_W+PRE_SH)'(n_na[c])
                                  >= ((SUM_W+PRE_SH)'(n_nw) << PRE_SH);
                r_dv_rem[c][0] <= REM_W'(n_na[c] >> PRE_SH);
                r_dv_quo[c][0] <= {n_na[c][PRE_SH-1:0], {FRAC_BITS{1'b0}}};
            end
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_div
        logic [REM_W-1:0] w_t [3];
        logic             w_ge [3];
        always_comb begin
            for (int c = 0; c < 3; c++) begin
                w_t[c]  = {r_dv_rem[c][k-1][REM_W-2:0], r_dv_quo[c][k-1][QUO_W-1]};
                w_ge[c] = w_t[c] >= {1'b0, r_dv_nw[k-1]};
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k] <= 1'b0;
            end else if (w_en) begin
                r_dv_v[k] <= r_dv_v[k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_zero[k] <= r_dv_zero[k-1];
                r_dv_nw[k]   <= r_dv_nw[k-1];
                for (int c = 0; c < 3; c++) begin
                    r_dv_neg[c][k] <= r_dv_neg[c][k-1];
                    r_dv_ovf[c][k] <= r_dv_ovf[c][k-1];
                    r_dv_rem[c][k] <= w_ge[c] ? w_t[c] - {1'b0, r_dv_nw[k-1]} : w_t[c];
                    r_dv_quo[c][k] <= {r_dv_quo[c][k-1][QUO_W-2:0], w_ge[c]};
                end
            end
        end
    end

    // final 1: cap, sign, add one half; screen y uses one minus ny
    logic                    r_f1_v;
    logic                    r_f1_zero;
    logic signed [NDC_W-1:0] r_f1_nx;
    logic signed [NDC_W:0]   r_f1_ny;
    logic signed [NDC_W-1:0] r_f1_nz;
    logic signed [NDC_W-1:0] n_f1_nd [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic [QUO_W-1:0] mag;
            mag = (r_dv_ovf[c][QUO_W] || (r_dv_quo[c][QUO_W] > CAP_C))
                  ? CAP_C : r_dv_quo[c][QUO_W];
            n_f1_nd[c] = (r_dv_neg[c][QUO_W] ? -NDC_W'(mag) : NDC_W'(mag)) + HALF_C;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else if (w_en) begin
            r_f1_v <= r_dv_v[QUO_W];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_zero <= r_dv_zero[QUO_W];
            r_f1_nx   <= n_f1_nd[0];
            r_f1_ny   <= ONE_C - (NDC_W+1)'(n_f1_nd[1]);
            r_f1_nz   <= n_f1_nd[2];
        end
    end

    // final 2: viewport multiply
    logic                    r_f2_v;
    logic                    r_f2_zero;
    logic signed [SCR_W-1:0] r_f2_sx;
    logic signed [SCR_W-1:0] r_f2_sy;
    logic signed [NDC_W-1:0] r_f2_nz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_v <= 1'b0;
        end else if (w_en) begin
            r_f2_v <= r_f1_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f2_zero <= r_f1_zero;
            r_f2_sx   <= SCR_W'(r_f1_nx) * SCR_W'($signed({1'b0, r_width}));
            r_f2_sy   <= SCR_W'(r_f1_ny) * SCR_W'($signed({1'b0, r_height}));
            r_f2_nz   <= r_f1_nz;
        end
    end

    // output register: saturate, zero w forces zero results
    logic                  r_out_v;
    logic                  r_out_zero;
    logic [OUT_DATA_W-1:0] r_out_data;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= r_f2_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_zero <= r_f2_zero;
            if (r_f2_zero) begin
                r_out_data <= '0;
            end else begin
                r_out_data <= {sat32(SCR_W'(r_f2_nz)), sat32(r_f2_sy), sat32(r_f2_sx)};
            end
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_zero;

    // checks
    a_zero_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("w_zero result with nonzero data");

    a_load_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_s_axis_tuser == OP_LOAD)) |=> !r_s0_v)
        else $error("load transaction entered the pipeline");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_s2_sum[3]) && $stable(r_f1_v) && $stable(r_dv_v[QUO_W])))
        else $error("pipeline moved during stall");

    a_valid_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_f2_v) |=> r_out_v)
        else $error("result lost between last stages");

endmodule

>>> tb/sv/vertex_transform_project_core_tb.sv
// Testbench for vertex_transform_project_core: matrix loads, vertex transforms,
// screen-size settings and stream back-pressure, checked against a built-in predictor.
// Depends on vtp_pkg and the core RTL.
module vertex_transform_project_core_tb;
    import vtp_pkg::*;

    typedef struct packed {
        logic        w_zero;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] dep;
    } t_screen_pt;

    typedef struct packed {
        t_opcode     op;
        logic [3:0]  idx;
        logic [31:0] cval;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
    } t_vtx_item;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [IN_DATA_W-1:0] s_data = '0;
    logic s_user = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [OUT_DATA_W-1:0] m_data;
    logic m_user;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    t_cfg_index cfg_index = CFG_WIDTH;
    logic [DIM_W-1:0] cfg_data = '0;

    // Predictor state
    longint mat[16];
    longint scr_w, scr_h;

    t_vtx_item   pending_q[$];
    t_screen_pt  expected_pts[$];
    int errors = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_off = 0;

    vertex_transform_project_core u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic longint floor_frac(longint p);
        return p >>> FRAC_BITS;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Quotient with FRAC_BITS fraction bits, toward zero, magnitude capped at 2^40
    function automatic longint ndc_quotient(longint a, longint w);
        logic neg;
        longint unsigned na, nw, qi, r, mag, frac;
        longint cap;
        cap = longint'(1) << 40;
        neg = (a < 0) != (w < 0);
        na = (a < 0) ? -a : a;
        nw = (w < 0) ? -w : w;
        qi = na / nw;
        r = na % nw;
        if (qi > (cap >> FRAC_BITS)) begin
            mag = cap;
        end else begin
            // fraction bits one at a time so the remainder never overflows
            frac = 0;
            for (int i = 0; i < FRAC_BITS; i++) begin
                r = r << 1;
                frac = frac << 1;
                if (r >= nw) begin
                    r = r - nw;
                    frac = frac | 1;
                end
            end
            mag = (qi << FRAC_BITS) | frac;
            if (mag > cap) mag = cap;
        end
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint row_sum(int row, longint x, longint y, longint z);
        return floor_frac(mat[row*4] * x) + floor_frac(mat[row*4+1] * y)
             + floor_frac(mat[row*4+2] * z) + mat[row*4+3];
    endfunction

    // Apply one accepted item to the predictor
    task automatic project_vertex(t_vtx_item it);
        longint x, y, z, tx, ty, tz, tw, one, half, nx, ny, nz;
        t_screen_pt pt;
        if (it.op == OP_LOAD) begin
            mat[it.idx] = longint'(signed'(it.cval));
            return;
        end
        x = longint'(signed'(it.vx));
        y = longint'(signed'(it.vy));
        z = longint'(signed'(it.vz));
        tx = row_sum(0, x, y, z);
        ty = row_sum(1, x, y, z);
        tz = row_sum(2, x, y, z);
        tw = row_sum(3, x, y, z);
        pt = '0;
        if (tw == 0) begin
            pt.w_zero = 1'b1;
        end else begin
            one = longint'(1) << FRAC_BITS;
            half = one >> 1;
            nx = ndc_quotient(tx, tw) + half;
            ny = ndc_quotient(ty, tw) + half;
            nz = ndc_quotient(tz, tw) + half;
            pt.sx = 32'(clamp32(nx * scr_w));
            pt.sy = 32'(clamp32((one - ny) * scr_h));
            pt.dep = 32'(clamp32(nz));
        end
        expected_pts.push_back(pt);
    endtask

    // Driver: present queued items, idle at random
    always @(posedge clk) begin
        if (rst_n) begin
            if (!s_valid || s_ready) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    t_vtx_item it;
                    it = pending_q.pop_front();
                    project_vertex(it);
                    s_valid <= 1'b1;
                    s_user <= it.op;
                    s_data <= IN_DATA_W'({it.vz, it.vy, it.vx, it.cval, it.idx});
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest expectation
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_valid && m_ready) begin
                if (expected_pts.size() == 0) begin
                    $display("%0t: unexpected result tdata=%h tuser=%b", $time, m_data, m_user);
                    errors++;
                end else begin
                    t_screen_pt e;
                    e = expected_pts.pop_front();
                    if (m_data[31:0] !== e.sx) begin
                        $display("%0t: screen_x exp %h got %h", $time, e.sx, m_data[31:0]);
                        errors++;
                    end
                    if (m_data[63:32] !== e.sy) begin
                        $display("%0t: screen_y exp %h got %h", $time, e.sy, m_data[63:32]);
                        errors++;
                    end
                    if (m_data[95:64] !== e.dep) begin
                        $display("%0t: depth exp %h got %h", $time, e.dep, m_data[95:64]);
                        errors++;
                    end
                    if (m_user !== e.w_zero) begin
                        $display("%0t: w_zero exp %b got %b", $time, e.w_zero, m_user);
                        errors++;
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return 32'($urandom_range(20 << 16)) - (32'd10 << 16);
        endcase
    endfunction

    function automatic logic [31:0] rand_coeff();
        case ($urandom_range(4))
            0: return $urandom();
            1: return 32'h0001_0000;
            2: return 32'h0;
            default: return 32'($urandom_range(4 << 16)) - (32'd2 << 16);
        endcase
    endfunction

    task automatic push_load(int idx, logic [31:0] v);
        t_vtx_item it;
        it.op = OP_LOAD; it.idx = 4'(idx); it.cval = v;
        it.vx = $urandom(); it.vy = $urandom(); it.vz = $urandom();
        pending_q.push_back(it);
    endtask

    task automatic push_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_vtx_item it;
        it.op = OP_TRANSFORM; it.idx = 4'($urandom()); it.cval = $urandom();
        it.vx = x; it.vy = y; it.vz = z;
        pending_q.push_back(it);
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || s_valid || expected_pts.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_index ix, logic [DIM_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= ix;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (ix == CFG_WIDTH) scr_w = v; else scr_h = v;
    endtask

    // Random phase: mostly vertices, some coefficient loads
    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 15) push_load($urandom_range(15), rand_coeff());
            else push_vertex(rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    initial begin
        for (int i = 0; i < 16; i++) mat[i] = (i % 5 == 0) ? (longint'(1) << FRAC_BITS) : 0;
        scr_w = 640;
        scr_h = 480;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity, extremes, zero w, perspective divide
        push_vertex(32'h0, 32'h0, 32'h0);
        push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        push_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
        push_vertex(32'h0000_8000, 32'hFFFF_8000, 32'h0000_4000);
        push_load(15, 32'h0);
        push_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        push_load(14, 32'hFFFF_0000);
        push_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        push_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        push_load(14, 32'h0000_0001);
        push_vertex(32'h7FFF_0000, 32'h0, 32'h0000_0001);
        push_load(3, 32'h7FFF_FFFF);
        push_load(7, 32'h8000_0000);
        push_vertex(32'h0, 32'h0, 32'h0001_0000);
        push_load(15, 32'h0001_0000);
        push_load(14, 32'h0);
        push_load(3, 32'h0);
        push_load(7, 32'h0);
        drain();

        write_reg(CFG_WIDTH, 13'd1);
        write_reg(CFG_HEIGHT, 13'd4096);
        src_idle_pct = 51;
        random_phase(150);
        drain();

        write_reg(CFG_WIDTH, 13'h1FFF);
        write_reg(CFG_HEIGHT, 13'd0);
        src_idle_pct = 0;
        sink_stall_pct = 51;
        random_phase(150);
        drain();

        write_reg(CFG_WIDTH, 13'd0);
        write_reg(CFG_HEIGHT, 13'h1FFF);
        src_idle_pct = 34;
        sink_stall_pct = 34;
        random_phase(150);
        drain();

        // Long receiver hold-off so the pipeline fills and stalls its input
        write_reg(CFG_WIDTH, 13'd4096);
        write_reg(CFG_HEIGHT, 13'd1);
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_off = 300;
        random_phase(150);
        drain();

        write_reg(CFG_WIDTH, 13'd1920);
        write_reg(CFG_HEIGHT, 13'd1080);
        random_phase(150);
        drain();

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end
endmodule
